// ===== rtl/bfa_pkg.sv =====
package bfa_pkg;

   localparam int ArenaCount     = 2;
   localparam int MaxArenaFrames = 4096;
   localparam int BytesPerArena  = MaxArenaFrames / 8;
   localparam int ByteIdxWidth   = $clog2(BytesPerArena);
   localparam int ArenaIdxWidth  = (ArenaCount > 1) ? $clog2(ArenaCount) : 1;
   localparam int MemAddrWidth   = ArenaIdxWidth + ByteIdxWidth;
   localparam int MemDepth       = ArenaCount * BytesPerArena;
   localparam int FrameWidth     = 52;
   localparam int LenWidth       = 13;
   localparam int CountWidth     = 16;
   localparam int OffWidth       = $clog2(MaxArenaFrames) + 1;
   localparam int TakenMax       = 8191;

   localparam logic [1:0] KindAlloc = 2'd0;
   localparam logic [1:0] KindFree  = 2'd1;
   localparam logic [1:0] KindMark  = 2'd2;
   localparam logic [1:0] KindNop   = 2'd3;

   localparam logic [1:0] StatusOk      = 2'd0;
   localparam logic [1:0] StatusNoFree  = 2'd1;
   localparam logic [1:0] StatusNoArena = 2'd2;

   localparam logic [1:0] RegArena0Base = 2'd0;

   typedef struct packed {
      logic [1:0]            kind;
      logic [FrameWidth-1:0] frame_number;
      logic [CountWidth-1:0] frame_count;
   } req_type;

   typedef struct packed {
      logic [FrameWidth-1:0] result_frame;
      logic [1:0]            status;
      logic                  arena_index;
   } rsp_type;

   typedef struct packed {
      logic                    we;
      logic [MemAddrWidth-1:0] waddr;
      logic [7:0]              wdata;
      logic                    re;
      logic [MemAddrWidth-1:0] raddr;
   } mem_ctl_type;

endpackage

// ===== rtl/bitmap_frame_allocator.sv =====
// Bitmap frame allocator over two arenas of up to 4096 frames each, with the
// bitmap held in one byte-wide synchronous RAM of 1024 entries. After reset the
// block clears all 1024 RAM entries before it takes its first item
// (configuration writes are taken throughout). Allocate reads one bitmap byte
// at a time from the arena's hint, wrapping to the first byte at the end. Free
// clears the frame's bit in every arena that holds the frame; mark-range sets
// the bit of each frame in the range in an arena that holds it. One item is
// in work at a time; the result waits in an output register while the next
// item is taken.
module bitmap_frame_allocator (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  bfa_pkg::req_type                    req_data,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output bfa_pkg::rsp_type                    rsp_data,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [1:0]                          csr_index,
   input  logic [bfa_pkg::FrameWidth-1:0]      csr_data
);
   import bfa_pkg::*;

   typedef enum logic [3:0] {
      ST_CLEAR, ST_IDLE, ST_PICK, ST_SREAD, ST_SCHK, ST_FREE_RD, ST_FREE_WR,
      ST_MARK_STEP, ST_MARK_RD, ST_MARK_WR, ST_DONE
   } state_type;

   state_type                   state_ff;
   logic [FrameWidth-1:0]       base_ff [ArenaCount];
   logic [LenWidth-1:0]         len_ff [ArenaCount];
   logic [LenWidth-1:0]         taken_ff [ArenaCount];
   logic [ByteIdxWidth-1:0]     hint_ff [ArenaCount];
   req_type                     req_ff;
   logic                        rsp_valid_ff;
   rsp_type                     rsp_ff;
   rsp_type                     res_ff;
   logic [MemAddrWidth:0]       clr_ff;
   logic [ArenaIdxWidth-1:0]    arena_ff;
   logic [ByteIdxWidth:0]       idx_ff;
   logic [ByteIdxWidth:0]       scanned_ff;
   logic [ByteIdxWidth:0]       nbytes_ff;
   logic [OffWidth-1:0]         off_ff;
   logic                        found_ff;
   logic [FrameWidth:0]         frame_ff;
   logic [CountWidth-1:0]       left_ff;
   logic                        have_ff;
   logic                        any_ff;
   logic [ArenaIdxWidth:0]      ai_ff;

   mem_ctl_type ctl;
   logic [7:0]  rdata;

   bfa_bitmap_mem u_mem (.clock(clock), .ctl(ctl), .rdata(rdata));

   function automatic logic [LenWidth-1:0] eff_len(input logic [LenWidth-1:0] l);
      eff_len = (l > LenWidth'(MaxArenaFrames)) ? LenWidth'(MaxArenaFrames) : l;
   endfunction

   function automatic logic holds(input logic [FrameWidth:0] f,
                                  input logic [FrameWidth-1:0] b,
                                  input logic [LenWidth-1:0] l);
      logic [FrameWidth:0] d;
      d = f - {1'b0, b};
      holds = (f >= {1'b0, b}) && (d < (FrameWidth+1)'(eff_len(l)));
   endfunction

   function automatic logic [MemAddrWidth-1:0] maddr(input logic [ArenaIdxWidth-1:0] a,
                                                   input logic [ByteIdxWidth-1:0] i);
      maddr = {a, i};
   endfunction

   assign req_ready = (state_ff == ST_IDLE);
   assign csr_ready = 1'b1;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // combinational helpers
   logic [LenWidth-1:0]     cur_len;
   logic [ByteIdxWidth:0]   cur_byte;
   logic [LenWidth:0]       lo;
   logic [7:0]              view;
   logic [2:0]              bitpos;
   logic [OffWidth-1:0]     mark_off;
   logic [FrameWidth:0]     diff_mark;
   logic [ArenaIdxWidth-1:0] ai_s;
   logic                    mark_hit;
   logic [ArenaIdxWidth-1:0] mark_pick;

   always_comb begin
      cur_len  = eff_len(len_ff[arena_ff]);
      cur_byte = idx_ff - 1'b1;
      lo       = (LenWidth+1)'({cur_byte, 3'b000});
      view     = rdata;
      if (lo >= (LenWidth+1)'(cur_len)) begin
         view = 8'hFF;
      end else if ((LenWidth+1)'(cur_len) - lo < (LenWidth+1)'(8)) begin
         view = rdata | (8'hFF << 3'((LenWidth+1)'(cur_len) - lo));
      end
      bitpos = 3'd7;
      for (int j = 6; j >= 0; j--) begin
         if (!view[j]) bitpos = 3'(j);
      end
      diff_mark = frame_ff - {1'b0, base_ff[arena_ff]};
      mark_off  = OffWidth'(diff_mark);
      ai_s      = ai_ff[ArenaIdxWidth-1:0];
      // lowest arena that holds the current frame
      mark_hit  = 1'b0;
      mark_pick = '0;
      for (int a = ArenaCount - 1; a >= 0; a--) begin
         if (holds(frame_ff, base_ff[a], len_ff[a])) begin
            mark_hit  = 1'b1;
            mark_pick = ArenaIdxWidth'(a);
         end
      end
   end

   always_comb begin
      ctl = '0;
      case (state_ff)
         ST_CLEAR: begin
            ctl.we    = 1'b1;
            ctl.waddr = clr_ff[MemAddrWidth-1:0];
         end
         ST_SREAD: begin
            ctl.re    = 1'b1;
            ctl.raddr = maddr(arena_ff, idx_ff[ByteIdxWidth-1:0]);
         end
         ST_FREE_RD, ST_MARK_RD: begin
            ctl.re    = 1'b1;
            ctl.raddr = maddr(arena_ff, off_ff[OffWidth-2:3]);
         end
         ST_FREE_WR: begin
            ctl.we    = 1'b1;
            ctl.waddr = maddr(arena_ff, off_ff[OffWidth-2:3]);
            ctl.wdata = rdata & ~(8'd1 << off_ff[2:0]);
         end
         ST_MARK_WR: begin
            ctl.we    = 1'b1;
            ctl.waddr = maddr(arena_ff, off_ff[OffWidth-2:3]);
            ctl.wdata = rdata | (8'd1 << off_ff[2:0]);
         end
         ST_SCHK: begin
            if (view != 8'hFF) begin
               ctl.we    = 1'b1;
               ctl.waddr = maddr(arena_ff, cur_byte[ByteIdxWidth-1:0]);
               ctl.wdata = rdata | (8'd1 << bitpos);
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         for (int a = 0; a < ArenaCount; a++) begin
            base_ff[a]  <= '0;
            len_ff[a]   <= '0;
            taken_ff[a] <= '0;
            hint_ff[a]  <= '0;
         end
      end else begin
         if (csr_valid) begin
            if (csr_index[1] == 1'b0 || ArenaCount > 1) begin
               if (csr_index[0] == RegArena0Base[0]) begin
                  base_ff[ArenaIdxWidth'(csr_index[1])] <= csr_data;
               end else begin
                  len_ff[ArenaIdxWidth'(csr_index[1])] <= csr_data[LenWidth-1:0];
               end
            end
         end
         if (state_ff == ST_DONE && (!rsp_valid_ff || rsp_ready)) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_valid_ff && rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            ST_CLEAR: begin
               clr_ff <= clr_ff + 1'b1;
               if (clr_ff == (MemAddrWidth+1)'(MemDepth - 1)) state_ff <= ST_IDLE;
            end
            ST_IDLE: begin
               if (req_valid && req_ready) begin
                  req_ff        <= req_data;
                  res_ff        <= '0;
                  ai_ff         <= '0;
                  found_ff      <= 1'b0;
                  frame_ff      <= {1'b0, req_data.frame_number};
                  left_ff       <= req_data.frame_count;
                  have_ff       <= 1'b0;
                  any_ff        <= 1'b0;
                  state_ff      <= ST_PICK;
               end
            end
            ST_PICK: begin
               case (req_ff.kind)
                  KindAlloc: begin
                     if (ai_ff == (ArenaIdxWidth+1)'(ArenaCount)) begin
                        res_ff.status <= StatusNoFree;
                        state_ff      <= ST_DONE;
                     end else if (taken_ff[ai_s] < eff_len(len_ff[ai_s])) begin
                        arena_ff   <= ai_s;
                        res_ff.arena_index <= ai_s[0];
                        nbytes_ff  <= (ByteIdxWidth+1)'((eff_len(len_ff[ai_s]) + 7) >> 3);
                        idx_ff     <= ((ByteIdxWidth+1)'(hint_ff[ai_s]) >
                                       (ByteIdxWidth+1)'((eff_len(len_ff[ai_s]) + 7) >> 3))
                                      ? (ByteIdxWidth+1)'((eff_len(len_ff[ai_s]) + 7) >> 3)
                                      : (ByteIdxWidth+1)'(hint_ff[ai_s]);
                        scanned_ff <= '0;
                        state_ff   <= ST_SREAD;
                     end else begin
                        ai_ff <= ai_ff + 1'b1;
                     end
                  end
                  KindFree: begin
                     if (ai_ff == (ArenaIdxWidth+1)'(ArenaCount)) begin
                        res_ff.status <= found_ff ? StatusOk : StatusNoArena;
                        state_ff      <= ST_DONE;
                     end else if (holds(frame_ff, base_ff[ai_s], len_ff[ai_s])) begin
                        arena_ff <= ai_s;
                        off_ff   <= OffWidth'(frame_ff - {1'b0, base_ff[ai_s]});
                        if (!found_ff) res_ff.arena_index <= ai_s[0];
                        found_ff <= 1'b1;
                        state_ff <= ST_FREE_RD;
                     end else begin
                        ai_ff <= ai_ff + 1'b1;
                     end
                  end
                  KindMark: begin
                     state_ff <= ST_MARK_STEP;
                  end
                  default: state_ff <= ST_DONE;
               endcase
            end
            ST_SREAD: begin
               if (scanned_ff == nbytes_ff) begin
                  res_ff.status <= StatusNoFree;
                  state_ff      <= ST_DONE;
               end else begin
                  if (idx_ff == nbytes_ff) begin
                     idx_ff <= '0;
                  end else begin
                     idx_ff     <= idx_ff + 1'b1;
                     scanned_ff <= scanned_ff + 1'b1;
                     state_ff   <= ST_SCHK;
                  end
               end
            end
            ST_SCHK: begin
               if (view != 8'hFF) begin
                  if (taken_ff[arena_ff] < LenWidth'(TakenMax))
                     taken_ff[arena_ff] <= taken_ff[arena_ff] + 1'b1;
                  hint_ff[arena_ff]    <= cur_byte[ByteIdxWidth-1:0];
                  res_ff.result_frame  <= base_ff[arena_ff] +
                                          FrameWidth'({cur_byte, bitpos});
                  res_ff.status        <= StatusOk;
                  state_ff             <= ST_DONE;
               end else begin
                  state_ff <= ST_SREAD;
               end
            end
            ST_FREE_RD: state_ff <= ST_FREE_WR;
            ST_FREE_WR: begin
               if (rdata[off_ff[2:0]] && taken_ff[arena_ff] != '0)
                  taken_ff[arena_ff] <= taken_ff[arena_ff] - 1'b1;
               hint_ff[arena_ff] <= off_ff[OffWidth-2:3];
               ai_ff    <= ai_ff + 1'b1;
               state_ff <= ST_PICK;
            end
            ST_MARK_STEP: begin
               if (left_ff == '0) begin
                  res_ff.status <= (req_ff.frame_count != '0 && !any_ff)
                                   ? StatusNoArena : StatusOk;
                  state_ff      <= ST_DONE;
               end else if (have_ff && holds(frame_ff, base_ff[arena_ff], len_ff[arena_ff])) begin
                  off_ff   <= mark_off;
                  state_ff <= ST_MARK_RD;
               end else if (mark_hit) begin
                  arena_ff <= mark_pick;
                  have_ff  <= 1'b1;
                  off_ff   <= OffWidth'(frame_ff - {1'b0, base_ff[mark_pick]});
                  state_ff <= ST_MARK_RD;
               end else begin
                  have_ff  <= 1'b0;
                  frame_ff <= frame_ff + 1'b1;
                  left_ff  <= left_ff - 1'b1;
               end
            end
            ST_MARK_RD: state_ff <= ST_MARK_WR;
            ST_MARK_WR: begin
               if (!rdata[off_ff[2:0]] && taken_ff[arena_ff] < LenWidth'(TakenMax))
                  taken_ff[arena_ff] <= taken_ff[arena_ff] + 1'b1;
               if (!any_ff) res_ff.arena_index <= arena_ff[0];
               any_ff   <= 1'b1;
               frame_ff <= frame_ff + 1'b1;
               left_ff  <= left_ff - 1'b1;
               state_ff <= ST_MARK_STEP;
            end
            ST_DONE: begin
               if (!rsp_valid_ff || rsp_ready) begin
                  rsp_ff   <= res_ff;
                  state_ff <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end
endmodule

// ===== rtl/bfa_bitmap_mem.sv =====
module bfa_bitmap_mem (
   input  logic                      clock,
   input  bfa_pkg::mem_ctl_type      ctl,
   output logic [7:0]                rdata
);
   import bfa_pkg::*;

   logic [7:0] mem_ff [MemDepth];
   logic [7:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (ctl.we) begin
         mem_ff[ctl.waddr] <= ctl.wdata;
      end
      if (ctl.re) begin
         rdata_ff <= mem_ff[ctl.raddr];
      end
   end

   assign rdata = rdata_ff;
endmodule
